@@ rtl/mbfi_pkg.sv @@
// Package for the mailbox and FIFO interface: access, target and status codes
// and the control word constants. No dependencies.
`timescale 1ns / 1ps

package mbfi_pkg;

  // access kinds
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_CLR   = 2'd3;

  // access targets
  localparam logic [3:0] TGT_CTRL_EE  = 4'd0;
  localparam logic [3:0] TGT_CTRL_IOP = 4'd1;
  localparam logic [3:0] TGT_BD6      = 4'd2;
  localparam logic [3:0] TGT_MS_MBOX  = 4'd3;
  localparam logic [3:0] TGT_SM_MBOX  = 4'd4;
  localparam logic [3:0] TGT_MS_FLAGS = 4'd5;
  localparam logic [3:0] TGT_SM_FLAGS = 4'd6;
  localparam logic [3:0] TGT_FIFO0    = 4'd7;
  localparam logic [3:0] TGT_FIFO1    = 4'd8;
  localparam logic [3:0] TGT_LEVEL0   = 4'd9;
  localparam logic [3:0] TGT_LEVEL1   = 4'd10;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // control word bits
  localparam logic [31:0] EE_CTRL_MASK  = 32'h0000_0100;
  localparam logic [31:0] IOP_TOGGLE    = 32'h0000_00F0;
  localparam logic [31:0] IOP_REINIT    = 32'h0000_00A0;
  localparam logic [31:0] IOP_CLR_FIELD = 32'h0000_F000;
  localparam logic [31:0] IOP_SET_FIELD = 32'h0000_2000;

endpackage

@@ rtl/mbfi_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered
// read data and read enable. No dependencies.
`timescale 1ns / 1ps

module mbfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mailbox_and_fifo_interface.sv @@
// The state update, FIFO RAM read and pending entry are registered when an item is
// accepted; the result register loads the pending entry once the output is free.
// Throughput: one item per cycle while the output drains, bound by the single read
// port of each FIFO RAM. One more item is taken while a result waits at the output.
// Reset (synchronous): state and valid registers zero, both FIFOs empty; RAM contents
// are left as is, as only pushed words are ever read; there is no clearing pass.
`timescale 1ns / 1ps

module mailbox_and_fifo_interface
  import mbfi_pkg::*;
#(
  parameter int FIFO0_DEPTH = 32,
  parameter int FIFO1_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  target,
  input  logic [31:0] data_word,
  input  logic [63:0] quad_low,
  input  logic [63:0] quad_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [1:0]  status
);

  localparam int AW0 = (FIFO0_DEPTH > 1) ? $clog2(FIFO0_DEPTH) : 1;
  localparam int CW0 = $clog2(FIFO0_DEPTH + 1);
  // fifo1 is split over four banks so a 128-bit push writes one word per bank
  localparam int ROWS1 = (FIFO1_DEPTH + 3) / 4;
  localparam int RW1 = (ROWS1 > 1) ? $clog2(ROWS1) : 1;
  localparam int CW1 = $clog2(FIFO1_DEPTH + 1);

  localparam logic [AW0-1:0] LAST0     = AW0'(FIFO0_DEPTH - 1);
  localparam logic [CW0-1:0] FULL0     = CW0'(FIFO0_DEPTH);
  localparam logic [RW1-1:0] LAST_ROW1 = RW1'(ROWS1 - 1);
  localparam logic [CW1-1:0] FULL1     = CW1'(FIFO1_DEPTH);
  localparam logic [CW1-1:0] ROOM1     = CW1'(FIFO1_DEPTH - 4);

  typedef enum logic [1:0] {SRC_VALUE, SRC_FIFO0, SRC_FIFO1} src_t;

  typedef struct packed {
    src_t        src;
    logic [1:0]  bank;
    logic [31:0] value;
    logic [1:0]  status;
  } pend_t;

  logic [31:0] control_word, control_word_next;
  logic [31:0] bd6_word, bd6_word_next;
  logic [31:0] ms_mailbox, ms_mailbox_next;
  logic [31:0] sm_mailbox, sm_mailbox_next;
  logic [31:0] ms_flags, ms_flags_next;
  logic [31:0] sm_flags, sm_flags_next;

  logic [AW0-1:0] head0, head0_next, tail0, tail0_next;
  logic [CW0-1:0] count0, count0_next;
  logic [RW1-1:0] head1_row, head1_row_next, tail1_row, tail1_row_next;
  logic [1:0]     head1_bank, head1_bank_next, tail1_bank;
  logic [CW1-1:0] count1, count1_next;

  logic        in_accept;
  logic        pend_valid, pend_move;
  pend_t       pend, pend_next;
  logic [31:0] pend_data;

  logic        ram0_we, ram0_re;
  logic [31:0] ram0_q;
  logic        ram1_we, ram1_re;
  logic [RW1-1:0] bank_waddr [4];
  logic [31:0]    bank_wdata [4];
  logic [31:0]    bank_q [4];

  logic [31:0]  iop_tmp, iop_mask;
  logic [127:0] quad;
  logic [1:0]   word_sel;

  function automatic logic [AW0-1:0] inc0(input logic [AW0-1:0] p);
    inc0 = (p == LAST0) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RW1-1:0] inc_row1(input logic [RW1-1:0] r);
    inc_row1 = (r == LAST_ROW1) ? '0 : r + 1'b1;
  endfunction

  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = !pend_valid || pend_move;
  assign in_accept = in_valid && in_ready;
  assign quad      = {quad_high, quad_low};

  always_comb begin
    control_word_next = control_word;
    bd6_word_next     = bd6_word;
    ms_mailbox_next   = ms_mailbox;
    sm_mailbox_next   = sm_mailbox;
    ms_flags_next     = ms_flags;
    sm_flags_next     = sm_flags;
    head0_next        = head0;
    tail0_next        = tail0;
    count0_next       = count0;
    head1_row_next    = head1_row;
    head1_bank_next   = head1_bank;
    tail1_row_next    = tail1_row;
    count1_next       = count1;
    ram0_we           = 1'b0;
    ram0_re           = 1'b0;
    ram1_we           = 1'b0;
    ram1_re           = 1'b0;
    pend_next.src     = SRC_VALUE;
    pend_next.bank    = head1_bank;
    pend_next.value   = '0;
    pend_next.status  = ST_OK;

    // IOP write: optional upper-field reinit; masked bits cleared if any set, else set
    iop_mask = data_word & IOP_TOGGLE;
    iop_tmp  = control_word;
    if ((data_word & IOP_REINIT) != '0) begin
      iop_tmp = (iop_tmp & ~IOP_CLR_FIELD) | IOP_SET_FIELD;
    end
    iop_tmp = ((iop_tmp & iop_mask) != '0) ? (iop_tmp & ~iop_mask) : (iop_tmp | iop_mask);

    case (target)
      TGT_CTRL_EE, TGT_CTRL_IOP: begin
        if (action == ACT_READ) begin
          pend_next.value = control_word;
        end else if (action == ACT_WRITE) begin
          if (target == TGT_CTRL_EE) begin
            control_word_next = (control_word & ~EE_CTRL_MASK) | (data_word & EE_CTRL_MASK);
          end else begin
            control_word_next = iop_tmp;
          end
        end else begin
          pend_next.status = ST_BAD;
        end
      end
      TGT_BD6, TGT_MS_MBOX, TGT_SM_MBOX: begin
        if (action == ACT_READ) begin
          pend_next.value = (target == TGT_BD6) ? bd6_word :
                            (target == TGT_MS_MBOX) ? ms_mailbox : sm_mailbox;
        end else if (action == ACT_WRITE) begin
          if (target == TGT_BD6) bd6_word_next = data_word;
          else if (target == TGT_MS_MBOX) ms_mailbox_next = data_word;
          else sm_mailbox_next = data_word;
        end else begin
          pend_next.status = ST_BAD;
        end
      end
      TGT_MS_FLAGS: begin
        case (action)
          ACT_READ:  pend_next.value = ms_flags;
          ACT_SET:   ms_flags_next = ms_flags | data_word;
          ACT_CLR:   ms_flags_next = ms_flags & ~data_word;
          default:   pend_next.status = ST_BAD;
        endcase
      end
      TGT_SM_FLAGS: begin
        case (action)
          ACT_READ:  pend_next.value = sm_flags;
          ACT_SET:   sm_flags_next = sm_flags | data_word;
          ACT_CLR:   sm_flags_next = sm_flags & ~data_word;
          default:   pend_next.status = ST_BAD;
        endcase
      end
      TGT_FIFO0: begin
        if (action == ACT_READ) begin
          if (count0 == '0) begin
            pend_next.status = ST_EMPTY;
          end else begin
            ram0_re       = in_accept;
            pend_next.src = SRC_FIFO0;
            head0_next    = inc0(head0);
            count0_next   = count0 - 1'b1;
          end
        end else if (action == ACT_WRITE) begin
          if (count0 == FULL0) begin
            pend_next.status = ST_FULL;
          end else begin
            ram0_we     = in_accept;
            tail0_next  = inc0(tail0);
            count0_next = count0 + 1'b1;
          end
        end else begin
          pend_next.status = ST_BAD;
        end
      end
      TGT_FIFO1: begin
        if (action == ACT_READ) begin
          if (count1 == '0) begin
            pend_next.status = ST_EMPTY;
          end else begin
            ram1_re         = in_accept;
            pend_next.src   = SRC_FIFO1;
            head1_bank_next = head1_bank + 1'b1;
            if (head1_bank == 2'd3) head1_row_next = inc_row1(head1_row);
            count1_next     = count1 - 1'b1;
          end
        end else if (action == ACT_WRITE) begin
          if (count1 > ROOM1) begin
            pend_next.status = ST_FULL;
          end else begin
            // four words advance the tail by one full row, bank unchanged
            ram1_we        = in_accept;
            tail1_row_next = inc_row1(tail1_row);
            count1_next    = count1 + CW1'(4);
          end
        end else begin
          pend_next.status = ST_BAD;
        end
      end
      TGT_LEVEL0, TGT_LEVEL1: begin
        if (action == ACT_READ) begin
          pend_next.value = (target == TGT_LEVEL0) ? 32'(count0) : 32'(count1);
        end else begin
          pend_next.status = ST_BAD;
        end
      end
      default: pend_next.status = ST_BAD;
    endcase

    // bank j takes word (j - tail bank); banks below the tail bank land on the next row
    for (int j = 0; j < 4; j++) begin
      word_sel      = 2'(j) - tail1_bank;
      bank_wdata[j] = quad[32*word_sel +: 32];
      bank_waddr[j] = (2'(j) < tail1_bank) ? inc_row1(tail1_row) : tail1_row;
    end
  end

  mbfi_ram #(.WIDTH(32), .DEPTH(FIFO0_DEPTH)) u_fifo0_ram (
    .clk   (clk),
    .we    (ram0_we),
    .waddr (tail0),
    .wdata (data_word),
    .re    (ram0_re),
    .raddr (head0),
    .rdata (ram0_q)
  );

  for (genvar b = 0; b < 4; b++) begin : g_fifo1_bank
    mbfi_ram #(.WIDTH(32), .DEPTH(ROWS1)) u_fifo1_ram (
      .clk   (clk),
      .we    (ram1_we),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata[b]),
      .re    (ram1_re),
      .raddr (head1_row),
      .rdata (bank_q[b])
    );
  end

  always_comb begin
    case (pend.src)
      SRC_FIFO0: pend_data = ram0_q;
      SRC_FIFO1: pend_data = bank_q[pend.bank];
      default:   pend_data = pend.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= '0;
      bd6_word     <= '0;
      ms_mailbox   <= '0;
      sm_mailbox   <= '0;
      ms_flags     <= '0;
      sm_flags     <= '0;
      head0        <= '0;
      tail0        <= '0;
      count0       <= '0;
      head1_row    <= '0;
      head1_bank   <= '0;
      tail1_row    <= '0;
      tail1_bank   <= '0;
      count1       <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        control_word <= control_word_next;
        bd6_word     <= bd6_word_next;
        ms_mailbox   <= ms_mailbox_next;
        sm_mailbox   <= sm_mailbox_next;
        ms_flags     <= ms_flags_next;
        sm_flags     <= sm_flags_next;
        head0        <= head0_next;
        tail0        <= tail0_next;
        count0       <= count0_next;
        head1_row    <= head1_row_next;
        head1_bank   <= head1_bank_next;
        tail1_row    <= tail1_row_next;
        count1       <= count1_next;
        pend_valid   <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend <= pend_next;
    end
    if (pend_move) begin
      read_data <= pend_data;
      status    <= pend.status;
    end
  end

  a_fifo0_bound: assert property (@(posedge clk) disable iff (rst)
    count0 <= FULL0)
    else $error("fifo0 count above depth");

  a_fifo1_bound: assert property (@(posedge clk) disable iff (rst)
    count1 <= FULL1)
    else $error("fifo1 count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ram0_re |-> count0 != '0) and (ram1_re |-> count1 != '0))
    else $error("FIFO read issued while empty");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule
